// ===== design/fabd_pkg.sv =====
`timescale 1ns / 1ps
// Package of the face anchor box decoder: word types, constants and arithmetic helpers.
package fabd_pkg;

	typedef struct packed {
		logic        [15:0] confidence;
		logic signed [15:0] box_dx;
		logic signed [15:0] box_dy;
		logic signed [15:0] box_dw;
		logic signed [15:0] box_dh;
		logic        [31:0] mark_one;
		logic        [31:0] mark_two;
		logic        [31:0] mark_three;
		logic        [31:0] mark_four;
		logic        [31:0] mark_five;
	} in_word_t;

	typedef struct packed {
		logic               kind;
		logic        [17:0] anchor_number;
		logic signed [19:0] coord_x1;
		logic signed [19:0] coord_y1;
		logic signed [19:0] coord_x2;
		logic signed [19:0] coord_y2;
		logic        [15:0] score;
		logic               last;
	} out_word_t;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned NET_DIM_W  = 12;
	localparam int unsigned SCALE_W    = 24;
	localparam int unsigned SCORE_W    = 16;
	localparam int unsigned COUNT_W    = 18;
	localparam int unsigned LEVEL_W    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NET_WIDTH       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NET_HEIGHT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd4;

	localparam logic [NET_DIM_W-1:0] NET_DIM_RESET = 12'd640;
	localparam logic [SCALE_W-1:0]   SCALE_RESET   = 24'd65536;
	localparam logic [SCORE_W-1:0]   SCORE_RESET   = 16'd32768;
	localparam logic [LEVEL_W-1:0]   LEVEL_LAST    = 2'd2;

	localparam logic KIND_BOX  = 1'b0;
	localparam logic KIND_MARK = 1'b1;

	typedef logic signed [31:0] opnd_t;
	typedef logic signed [63:0] prod_t;

	// Reciprocals 2^32/D rounded up; exact for the operand ranges used here.
	localparam opnd_t DIV5_K  = 32'sd858993460;
	localparam opnd_t DIV6_K  = 32'sd715827883;
	localparam opnd_t DIV24_K = 32'sd178956971;
	localparam opnd_t Q28_ONE = 32'sd268435456;
	localparam prod_t RND28   = 64'sd134217728;

	localparam logic signed [19:0] COORD_MAX = 20'sh7FFFF;
	localparam logic signed [19:0] COORD_MIN = 20'sh80000;

	localparam int unsigned PC_W      = 5;
	localparam int unsigned MARK_W    = 3;
	localparam int unsigned EXP_STEPS = 10;
	localparam int unsigned BOX_STEPS = 26;
	localparam int unsigned LM_STEPS  = 4;

	typedef enum logic [4:0] {
		STEP_Z, STEP_Z2, STEP_Z3, STEP_Z4, STEP_Q3, STEP_Q4, STEP_SQ, STEP_SQL,
		STEP_OX, STEP_OY, STEP_LX, STEP_LY,
		STEP_PX1, STEP_PY1, STEP_PX2, STEP_PY2, STEP_PLX, STEP_PLY
	} step_t;

	typedef struct packed {
		logic              accept;
		logic              issue;
		logic              wb;
		logic              emit;
		step_t             step;
		logic              second;
		logic [MARK_W-1:0] mark;
		logic              kind;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic keep;
		logic out_free;
	} status_t;

	function automatic step_t box_step(input logic [PC_W-1:0] pc);
		step_t s;
		case (pc) inside
			5'd0, 5'd10: s = STEP_Z;
			5'd1, 5'd11: s = STEP_Z2;
			5'd2, 5'd12: s = STEP_Z3;
			5'd3, 5'd13: s = STEP_Z4;
			5'd4, 5'd14: s = STEP_Q3;
			5'd5, 5'd15: s = STEP_Q4;
			5'd6, 5'd7, 5'd8, 5'd16, 5'd17, 5'd18: s = STEP_SQ;
			5'd9, 5'd19: s = STEP_SQL;
			5'd20: s = STEP_OX;
			5'd21: s = STEP_OY;
			5'd22: s = STEP_PX1;
			5'd23: s = STEP_PY1;
			5'd24: s = STEP_PX2;
			5'd25: s = STEP_PY2;
			default: s = STEP_Z;
		endcase
		return s;
	endfunction

	function automatic step_t mark_step(input logic [1:0] pc);
		step_t s;
		case (pc)
			2'd0: s = STEP_LX;
			2'd1: s = STEP_LY;
			2'd2: s = STEP_PLX;
			default: s = STEP_PLY;
		endcase
		return s;
	endfunction

	// Shift right by 28 with rounding to nearest, ties away from zero.
	function automatic prod_t rshr28(input prod_t p);
		prod_t mag;
		prod_t sh;
		mag = p[63] ? -p : p;
		sh = (mag + RND28) >>> 28;
		return p[63] ? -sh : sh;
	endfunction

	// Quotient from a reciprocal product, with the operand's sign put back.
	function automatic opnd_t div_quot(input prod_t p, input logic neg);
		opnd_t q;
		q = opnd_t'(p[63:32]);
		return neg ? -q : q;
	endfunction

	function automatic logic signed [19:0] sat20(input prod_t r);
		logic signed [19:0] v;
		if (r > 64'sd524287) begin
			v = COORD_MAX;
		end else if (r < -64'sd524288) begin
			v = COORD_MIN;
		end else begin
			v = r[19:0];
		end
		return v;
	endfunction

endpackage

// ===== design/face_anchor_box_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the face anchor box decoder: controller, datapath and configuration port.
//
// Use: one detector word per anchor enters on in_valid/in_stall, in frame order. An
// internal counter walks the three pyramid levels (strides 8, 16, 32), rows, columns
// and the two anchor sizes, so the word carries no position. A word is taken at a
// clock edge with in_valid high and in_stall low.
// An anchor whose confidence does not exceed the threshold produces nothing and is
// taken without starting work; while the block is idle, such anchors stream at one per
// cycle. A kept anchor produces a box word and then one word per landmark on
// out_valid/out_stall, last marking its final word. All arithmetic goes through one
// shared 32x32 multiplier, each operation passing through an issue and a write-back
// state. While a kept anchor occupies the block, in_stall is high.
// When the receiver stalls, the result word is held in the output register and the
// sequencer waits before presenting the next one.
// Registers are written through cfg_valid/cfg_ready, which is always ready; they
// should be changed only while the block is idle.
// Reset returns the anchor counter to the first anchor of a frame and the registers
// to a 640x640 network, unit scale and a threshold of one half.
module face_anchor_box_decoder import fabd_pkg::*; #(
	parameter int unsigned MAX_NET_SIZE = 2048,
	parameter int unsigned LANDMARKS    = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;
	logic    cfg_we;

	// The register file never blocks a write.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// The controller owns sequencing only; every value lives in the datapath.
	fabd_ctrl #(
		.LANDMARKS(LANDMARKS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	fabd_dp #(
		.MAX_NET_SIZE(MAX_NET_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== design/fabd_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the face anchor box decoder: sequences the shared multiplier steps and results.
module fabd_ctrl import fabd_pkg::*; #(
	parameter int unsigned LANDMARKS = 5
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WB    = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [PC_W-1:0]   pc_q;
	logic [MARK_W-1:0] mark_q;
	logic              mark_phase_q;
	logic              accept;
	logic              pc_end;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign pc_end   = mark_phase_q ? (pc_q == PC_W'(LM_STEPS - 1))
	                               : (pc_q == PC_W'(BOX_STEPS - 1));

	always_comb begin
		cmd.accept = accept;
		cmd.issue  = (state_q == ST_ISSUE);
		cmd.wb     = (state_q == ST_WB);
		cmd.emit   = (state_q == ST_EMIT) && status.out_free;
		cmd.step   = mark_phase_q ? mark_step(pc_q[1:0]) : box_step(pc_q);
		cmd.second = !mark_phase_q && (pc_q >= PC_W'(EXP_STEPS))
		             && (pc_q < PC_W'(2 * EXP_STEPS));
		cmd.mark   = mark_q;
		cmd.kind   = mark_phase_q ? KIND_MARK : KIND_BOX;
		cmd.last   = mark_phase_q ? (mark_q == MARK_W'(LANDMARKS - 1)) : (LANDMARKS == 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pc_q         <= '0;
			mark_q       <= '0;
			mark_phase_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && status.keep) begin
						state_q      <= ST_ISSUE;
						pc_q         <= '0;
						mark_q       <= '0;
						mark_phase_q <= 1'b0;
					end
				end
				ST_ISSUE: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (pc_end) begin
						state_q <= ST_EMIT;
					end else begin
						pc_q    <= pc_q + 1'b1;
						state_q <= ST_ISSUE;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						pc_q <= '0;
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ISSUE;
							if (mark_phase_q) begin
								mark_q <= mark_q + 1'b1;
							end
							mark_phase_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_issue_then_wb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |=> state_q == ST_WB)
		else $error("write-back did not follow issue");

	a_drop_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !status.keep |=> state_q == ST_IDLE)
		else $error("dropped anchor started work");

	a_mark_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mark_phase_q |-> mark_q < MARK_W'(LANDMARKS))
		else $error("landmark counter out of range");

endmodule

// ===== design/fabd_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the face anchor box decoder: registers, anchor counter, multiplier and output stage.
module fabd_dp import fabd_pkg::*; #(
	parameter int unsigned MAX_NET_SIZE = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  in_word_t              in_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_data
);

	localparam int unsigned DIM_W = $clog2(MAX_NET_SIZE + 32);
	localparam int unsigned COL_W = $clog2(MAX_NET_SIZE / 8);

	logic [NET_DIM_W-1:0] net_width_q;
	logic [NET_DIM_W-1:0] net_height_q;
	logic [SCALE_W-1:0]   scale_x_q;
	logic [SCALE_W-1:0]   scale_y_q;
	logic [SCORE_W-1:0]   thr_q;

	logic [LEVEL_W-1:0] level_q;
	logic [COL_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               size_q;
	logic [COUNT_W-1:0] count_q;

	in_word_t           in_q;
	logic [COUNT_W-1:0] num_q;
	logic [3:0]         lm_q;
	opnd_t              cx_q, cy_q;
	opnd_t              z_q, z2_q, z3_q, z4_q, q3_q, e_q;
	opnd_t              hw_q, hh_q, ox_q, oy_q;
	logic signed [19:0] x1_q, y1_q, x2_q, y2_q;
	prod_t              prod_s1;
	logic               neg_s1;
	out_word_t          out_q;
	logic               out_valid_q;

	logic [LEVEL_W-1:0] lv;
	logic [2:0]         ls;
	logic [DIM_W-1:0]   eff_w, eff_h, cols, rows;
	logic [COL_W:0]     col_inc, row_inc;
	logic               frame_end;

	logic [31:0]        mark_w;
	opnd_t              d_exp, off_v, div_v, div_half, div_k, a_mul, b_mul, div_abs;
	logic               use_div;
	logic signed [15:0] off_src;
	prod_t              mul_full, r28;
	opnd_t              dq, r28_t, half_z2, hsize;
	logic [40:0]        hs_full;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [NET_DIM_W-1:0] d);
		logic [DIM_W-1:0] e;
		if (d == '0) begin
			e = DIM_W'(1);
		end else if (32'(d) > MAX_NET_SIZE) begin
			e = DIM_W'(MAX_NET_SIZE);
		end else begin
			e = DIM_W'(d);
		end
		return e;
	endfunction

	// Anchor position bookkeeping
	assign lv      = (level_q > LEVEL_LAST) ? LEVEL_LAST : level_q;
	assign ls      = 3'd3 + 3'(lv);
	assign eff_w   = eff_dim(net_width_q);
	assign eff_h   = eff_dim(net_height_q);
	assign cols    = (eff_w + DIM_W'((1 << ls) - 1)) >> ls;
	assign rows    = (eff_h + DIM_W'((1 << ls) - 1)) >> ls;
	assign col_inc = {1'b0, col_q} + 1'b1;
	assign row_inc = {1'b0, row_q} + 1'b1;
	// The last anchor of the last level: the whole counter starts a new frame.
	assign frame_end = size_q && !(DIM_W'(col_inc) < cols) && !(DIM_W'(row_inc) < rows)
	                   && !(level_q < LEVEL_LAST);

	assign status.keep     = in_data.confidence > thr_q;
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_width_q  <= NET_DIM_RESET;
			net_height_q <= NET_DIM_RESET;
			scale_x_q    <= SCALE_RESET;
			scale_y_q    <= SCALE_RESET;
			thr_q        <= SCORE_RESET;
			level_q      <= '0;
			row_q        <= '0;
			col_q        <= '0;
			size_q       <= 1'b0;
			count_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NET_WIDTH:       net_width_q  <= cfg_data[NET_DIM_W-1:0];
					REG_NET_HEIGHT:      net_height_q <= cfg_data[NET_DIM_W-1:0];
					REG_SCALE_X:         scale_x_q    <= cfg_data[SCALE_W-1:0];
					REG_SCALE_Y:         scale_y_q    <= cfg_data[SCALE_W-1:0];
					REG_SCORE_THRESHOLD: thr_q        <= cfg_data[SCORE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				count_q <= frame_end ? '0 : count_q + 1'b1;
				if (!size_q) begin
					size_q <= 1'b1;
				end else begin
					size_q <= 1'b0;
					if (DIM_W'(col_inc) < cols) begin
						col_q <= col_inc[COL_W-1:0];
					end else begin
						col_q <= '0;
						if (DIM_W'(row_inc) < rows) begin
							row_q <= row_inc[COL_W-1:0];
						end else begin
							row_q <= '0;
							if (level_q < LEVEL_LAST) begin
								level_q <= level_q + 1'b1;
							end else begin
								level_q <= '0;
							end
						end
					end
				end
			end
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			in_q  <= in_data;
			num_q <= count_q;
			lm_q  <= 4'd4 + {1'b0, lv, 1'b0} + {3'd0, size_q};
			cx_q  <= opnd_t'({col_q, 1'b1}) << (5'(ls) + 5'd15);
			cy_q  <= opnd_t'({row_q, 1'b1}) << (5'(ls) + 5'd15);
		end
	end

	// Operand selection for the shared multiplier
	always_comb begin
		case (cmd.mark)
			3'd0:    mark_w = in_q.mark_one;
			3'd1:    mark_w = in_q.mark_two;
			3'd2:    mark_w = in_q.mark_three;
			3'd3:    mark_w = in_q.mark_four;
			default: mark_w = in_q.mark_five;
		endcase
		case (cmd.step)
			STEP_OX: off_src = in_q.box_dx;
			STEP_OY: off_src = in_q.box_dy;
			STEP_LX: off_src = signed'(mark_w[15:0]);
			default: off_src = signed'(mark_w[31:16]);
		endcase
		d_exp    = opnd_t'(cmd.second ? in_q.box_dh : in_q.box_dw) <<< 12;
		off_v    = opnd_t'(off_src) <<< (lm_q + 4'd3);
		div_v    = d_exp;
		div_half = 32'sd2;
		div_k    = DIV5_K;
		use_div  = 1'b0;
		a_mul    = e_q;
		b_mul    = e_q;
		case (cmd.step)
			STEP_Z: begin
				use_div = 1'b1;
			end
			STEP_OX, STEP_OY, STEP_LX, STEP_LY: begin
				use_div = 1'b1;
				div_v   = off_v;
			end
			STEP_Q3: begin
				use_div  = 1'b1;
				div_v    = z3_q;
				div_half = 32'sd3;
				div_k    = DIV6_K;
			end
			STEP_Q4: begin
				use_div  = 1'b1;
				div_v    = z4_q;
				div_half = 32'sd12;
				div_k    = DIV24_K;
			end
			STEP_Z2: begin
				a_mul = z_q;
				b_mul = z_q;
			end
			STEP_Z3: begin
				a_mul = z2_q;
				b_mul = z_q;
			end
			STEP_Z4: begin
				a_mul = z2_q;
				b_mul = z2_q;
			end
			STEP_PX1: begin
				a_mul = cx_q + ox_q - hw_q;
				b_mul = opnd_t'(scale_x_q);
			end
			STEP_PY1: begin
				a_mul = cy_q + oy_q - hh_q;
				b_mul = opnd_t'(scale_y_q);
			end
			STEP_PX2: begin
				a_mul = cx_q + ox_q + hw_q;
				b_mul = opnd_t'(scale_x_q);
			end
			STEP_PY2: begin
				a_mul = cy_q + oy_q + hh_q;
				b_mul = opnd_t'(scale_y_q);
			end
			STEP_PLX: begin
				a_mul = cx_q + ox_q;
				b_mul = opnd_t'(scale_x_q);
			end
			STEP_PLY: begin
				a_mul = cy_q + oy_q;
				b_mul = opnd_t'(scale_y_q);
			end
			default: ;
		endcase
		div_abs = div_v[31] ? -div_v : div_v;
		if (use_div) begin
			a_mul = div_abs + div_half;
			b_mul = div_k;
		end
	end

	assign mul_full = a_mul * b_mul;

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			prod_s1 <= mul_full;
			neg_s1  <= use_div && div_v[31];
		end
	end

	// Write-back: rounding, quotient recovery and saturation
	assign r28     = rshr28(prod_s1);
	assign r28_t   = opnd_t'(r28[31:0]);
	assign dq      = div_quot(prod_s1, neg_s1);
	assign half_z2 = (z2_q + 32'sd1) >>> 1;
	assign hs_full = ({9'd0, r28[31:0]} << lm_q) + 41'd4096;
	assign hsize   = opnd_t'({4'd0, hs_full[40:13]});

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			case (cmd.step)
				STEP_Z:  z_q  <= dq;
				STEP_Z2: z2_q <= r28_t;
				STEP_Z3: z3_q <= r28_t;
				STEP_Z4: z4_q <= r28_t;
				STEP_Q3: q3_q <= dq;
				STEP_Q4: e_q  <= Q28_ONE + z_q + half_z2 + q3_q + dq;
				STEP_SQ: e_q  <= r28_t;
				STEP_SQL: begin
					e_q <= r28_t;
					if (cmd.second) begin
						hh_q <= hsize;
					end else begin
						hw_q <= hsize;
					end
				end
				STEP_OX, STEP_LX: ox_q <= dq;
				STEP_OY, STEP_LY: oy_q <= dq;
				STEP_PX1, STEP_PLX: x1_q <= sat20(r28);
				STEP_PY1, STEP_PLY: y1_q <= sat20(r28);
				STEP_PX2: x2_q <= sat20(r28);
				STEP_PY2: y2_q <= sat20(r28);
				default: ;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.kind          <= cmd.kind;
			out_q.anchor_number <= num_q;
			out_q.coord_x1      <= x1_q;
			out_q.coord_y1      <= y1_q;
			out_q.coord_x2      <= (cmd.kind == KIND_MARK) ? '0 : x2_q;
			out_q.coord_y2      <= (cmd.kind == KIND_MARK) ? '0 : y2_q;
			out_q.score         <= in_q.confidence;
			out_q.last          <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_wb_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> $past(cmd.issue))
		else $error("write-back without a product");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q)
		else $error("emitted word not presented");

	a_stalled_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(out_q))
		else $error("stalled result word changed");

endmodule
